// ===== rtl/tile_autotile_variant_select_core_defines.svh =====
// Assertion macros shared by the autotile variant selector RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the including module.
`ifndef TILE_AUTOTILE_VARIANT_SELECT_CORE_DEFINES_SVH
`define TILE_AUTOTILE_VARIANT_SELECT_CORE_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define TAVS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tavs assertion failed");

// Next-cycle implication, checked only outside reset.
`define TAVS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tavs assertion failed");

`endif

// ===== rtl/tavs_pkg.sv =====
// Types, codes and lookup tables for the autotile variant selector.
// No dependencies; used by every module of the block.
`default_nettype none

package tavs_pkg;

    localparam int ID_BITS_DEFAULT = 16;
    localparam int NB_COUNT        = 8;

    // Neighbour positions within the masks.
    localparam int NB_TL = 0;
    localparam int NB_T  = 1;
    localparam int NB_TR = 2;
    localparam int NB_L  = 3;
    localparam int NB_R  = 4;
    localparam int NB_BL = 5;
    localparam int NB_B  = 6;
    localparam int NB_BR = 7;

    localparam logic [2:0] MODE_EDGE8  = 3'd0;
    localparam logic [2:0] MODE_OUTER4 = 3'd1;
    localparam logic [2:0] MODE_VERT   = 3'd2;
    localparam logic [2:0] MODE_HORIZ  = 3'd3;
    localparam logic [2:0] MODE_CLING  = 3'd4;
    localparam logic [2:0] MODE_CLING2 = 3'd5;
    localparam logic [2:0] MODE_RANDOM = 3'd6;
    localparam logic [2:0] MODE_NONE   = 3'd7;

    localparam int         CFG_IDX_BITS = 1;
    localparam int         CFG_DATA_BITS = 16;
    localparam logic [0:0] CFG_RAISED_A = 1'b0;
    localparam logic [0:0] CFG_RAISED_B = 1'b1;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] self_id;
        logic [7:0]  in_map_mask;
        logic [7:0]  glue_mask;
        logic [63:0] upper_ids;
        logic [63:0] lower_ids;
        logic        self_flipped;
        logic        self_enabled;
        logic [1:0]  random_pick;
    } t_in_item;

    typedef struct packed {
        logic [2:0] cell_column;
        logic [2:0] cell_row;
        logic       handled;
    } t_out_item;

    // What the lanes hand to the merge stage.
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] link;
        logic       flipped;
        logic       raised;
        logic [1:0] pick;
    } t_stage;

    localparam logic [5:0] OUTER_CELL [16] = '{
        6'd12, 6'd11, 6'd15, 6'd8, 6'd14, 6'd7, 6'd13, 6'd2,
        6'd10, 6'd9,  6'd6,  6'd4, 6'd5,  6'd3, 6'd1,  6'd0
    };

    // Blob mask to cell (row * 8 + column); masks that cannot occur give cell 0.
    function automatic logic [5:0] blob_cell(input logic [7:0] m);
        logic [5:0] c;
        case (m)
            8'd0:    c = 6'd12;
            8'd2:    c = 6'd11;
            8'd8:    c = 6'd30;
            8'd10:   c = 6'd44;
            8'd11:   c = 6'd8;
            8'd16:   c = 6'd29;
            8'd18:   c = 6'd43;
            8'd22:   c = 6'd7;
            8'd24:   c = 6'd28;
            8'd26:   c = 6'd42;
            8'd27:   c = 6'd41;
            8'd30:   c = 6'd40;
            8'd31:   c = 6'd2;
            8'd64:   c = 6'd10;
            8'd66:   c = 6'd9;
            8'd72:   c = 6'd46;
            8'd74:   c = 6'd36;
            8'd75:   c = 6'd35;
            8'd80:   c = 6'd45;
            8'd82:   c = 6'd33;
            8'd86:   c = 6'd32;
            8'd88:   c = 6'd39;
            8'd90:   c = 6'd27;
            8'd91:   c = 6'd23;
            8'd94:   c = 6'd24;
            8'd95:   c = 6'd18;
            8'd104:  c = 6'd6;
            8'd106:  c = 6'd34;
            8'd107:  c = 6'd4;
            8'd120:  c = 6'd38;
            8'd122:  c = 6'd25;
            8'd123:  c = 6'd20;
            8'd126:  c = 6'd21;
            8'd127:  c = 6'd16;
            8'd208:  c = 6'd5;
            8'd210:  c = 6'd31;
            8'd214:  c = 6'd3;
            8'd216:  c = 6'd37;
            8'd218:  c = 6'd26;
            8'd219:  c = 6'd22;
            8'd222:  c = 6'd19;
            8'd223:  c = 6'd15;
            8'd248:  c = 6'd1;
            8'd250:  c = 6'd17;
            8'd251:  c = 6'd14;
            8'd254:  c = 6'd13;
            default: c = 6'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tavs_lane.sv =====
// One neighbour lane: decides whether a neighbour connects under the current mode.
// Depends on tavs_pkg for the mode codes.
`default_nettype none

module tavs_lane #(
    parameter int ID_BITS = tavs_pkg::ID_BITS_DEFAULT
) (
    input  wire logic [2:0]         i_mode,
    input  wire logic               i_in_map,
    input  wire logic               i_glue,
    input  wire logic [ID_BITS-1:0] i_id,
    input  wire logic [ID_BITS-1:0] i_self_id,
    output logic                    o_link
);
    import tavs_pkg::*;

    logic w_nonzero;
    logic w_same;

    assign w_nonzero = (i_id != '0);
    assign w_same    = (i_id == i_self_id);

    always_comb begin
        // A neighbour outside the map always counts as connected.
        if (!i_in_map) begin
            o_link = 1'b1;
        end else begin
            case (i_mode)
                MODE_CLING2: o_link = w_nonzero;
                MODE_CLING:  o_link = w_nonzero && (!w_same || i_glue);
                default:     o_link = w_same || i_glue;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tavs_merge.sv =====
// Merge stage: combines the eight lane link bits into a sprite-sheet cell per mode.
// Depends on tavs_pkg for the stage and result types, mode codes and tables.
`default_nettype none

module tavs_merge (
    input  wire tavs_pkg::t_stage i_stage,
    output tavs_pkg::t_out_item   o_item
);
    import tavs_pkg::*;

    logic [7:0] w_c;
    logic [7:0] w_blob;
    logic [5:0] w_blob_cell;
    logic [5:0] w_outer_cell;
    logic [3:0] w_outer_idx;
    logic       w_t, w_l, w_r, w_b;

    assign w_c = i_stage.link;
    assign w_t = w_c[NB_T];
    assign w_l = w_c[NB_L];
    assign w_r = w_c[NB_R];
    assign w_b = w_c[NB_B];

    // A diagonal counts only when both edges beside it connect.
    always_comb begin
        w_blob         = w_c;
        w_blob[NB_TL]  = w_c[NB_TL] && w_l && w_t;
        w_blob[NB_BL]  = w_c[NB_BL] && w_l && w_b;
        w_blob[NB_TR]  = w_c[NB_TR] && w_r && w_t;
        w_blob[NB_BR]  = w_c[NB_BR] && w_r && w_b;
    end

    assign w_blob_cell  = blob_cell(w_blob);
    assign w_outer_idx  = {w_b, w_r, w_l, w_t};
    assign w_outer_cell = OUTER_CELL[w_outer_idx];

    always_comb begin
        o_item.cell_column = 3'd0;
        o_item.cell_row    = 3'd0;
        o_item.handled     = 1'b1;
        case (i_stage.mode)
            MODE_EDGE8: begin
                o_item.cell_column = w_blob_cell[2:0];
                o_item.cell_row    = w_blob_cell[5:3];
            end
            MODE_OUTER4: begin
                o_item.cell_column = w_outer_cell[2:0];
                o_item.cell_row    = w_outer_cell[5:3] + (i_stage.raised ? 3'd2 : 3'd0);
            end
            MODE_VERT: begin
                if (w_t && w_b)  o_item.cell_column = 3'd1;
                else if (w_t)    o_item.cell_column = 3'd0;
                else if (w_b)    o_item.cell_column = 3'd2;
                else             o_item.cell_column = 3'd3;
            end
            MODE_HORIZ: begin
                if (w_l && w_r)  o_item.cell_column = 3'd1;
                else if (w_r)    o_item.cell_column = i_stage.flipped ? 3'd2 : 3'd0;
                else if (w_l)    o_item.cell_column = i_stage.flipped ? 3'd0 : 3'd2;
                else             o_item.cell_column = 3'd3;
            end
            MODE_CLING: begin
                if (w_b)         o_item.cell_column = 3'd3;
                else if (w_t)    o_item.cell_column = 3'd1;
                else if (w_r)    o_item.cell_column = 3'd2;
                else if (w_l)    o_item.cell_column = 3'd0;
                else             o_item.cell_column = 3'd4;
            end
            MODE_CLING2: begin
                if (w_t && !w_b)      o_item.cell_column = 3'd1;
                else if (w_t || w_b)  o_item.cell_column = 3'd3;
                else if (w_r)         o_item.cell_column = 3'd2;
                else if (w_l)         o_item.cell_column = 3'd0;
                else                  o_item.cell_column = 3'd3;
            end
            MODE_RANDOM: begin
                o_item.cell_column = {1'b0, i_stage.pick};
            end
            default: begin
                o_item.handled = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tile_autotile_variant_select_core.sv =====
// Top level of the autotile variant selector: eight neighbour lanes, a merge stage,
// configuration registers and the handshake pipeline. Depends on tavs_pkg, tavs_lane,
// tavs_merge and the assertion macro header.
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+-----------------------
//  in       | to core   | i_in_valid / o_in_stall   | i_in_data (t_in_item)
//  out      | from core | o_out_valid / i_out_stall | o_out_data (t_out_item)
//  cfg      | to core   | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One tile is accepted per clock while o_in_stall is low.
// The lanes feed a stage register, and the merge stage feeds the output register.
// An empty stage register takes a new beat while a finished result waits on a stalled
// output, so two beats are held before the input stalls.
// Reset is synchronous and clears the valid flags and both raised-id registers.
`default_nettype none
`include "tile_autotile_variant_select_core_defines.svh"

module tile_autotile_variant_select_core #(
    parameter int ID_BITS = tavs_pkg::ID_BITS_DEFAULT
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire tavs_pkg::t_in_item                   i_in_data,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output tavs_pkg::t_out_item                       o_out_data,
    input  wire logic                                 i_cfg_we,
    input  wire logic [tavs_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [tavs_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import tavs_pkg::*;

    logic [ID_BITS-1:0] r_raised_a;
    logic [ID_BITS-1:0] r_raised_b;

    logic [NB_COUNT-1:0] w_link;
    logic [ID_BITS-1:0]  w_self;
    t_stage              n_stage;
    t_stage              r_stage;
    logic                r_s1_valid;
    logic                n_s1_valid;
    t_out_item           w_merged;
    t_out_item           r_out;
    logic                r_out_valid;
    logic                n_out_valid;
    logic                w_out_ready;
    logic                w_s1_adv;
    logic                w_in_accept;

    assign w_self = i_in_data.self_id[ID_BITS-1:0];

    for (genvar k = 0; k < NB_COUNT; k++) begin : g_lane
        logic [15:0] w_id;
        if (k < 4) begin : g_up
            assign w_id = i_in_data.upper_ids[16*k +: 16];
        end else begin : g_lo
            assign w_id = i_in_data.lower_ids[16*(k-4) +: 16];
        end
        tavs_lane #(
            .ID_BITS (ID_BITS)
        ) u_lane (
            .i_mode    (i_in_data.mode),
            .i_in_map  (i_in_data.in_map_mask[k]),
            .i_glue    (i_in_data.glue_mask[k]),
            .i_id      (w_id[ID_BITS-1:0]),
            .i_self_id (w_self),
            .o_link    (w_link[k])
        );
    end

    always_comb begin
        n_stage.mode    = i_in_data.mode;
        n_stage.link    = w_link;
        n_stage.flipped = i_in_data.self_flipped;
        n_stage.raised  = i_in_data.self_enabled &&
                          ((w_self == r_raised_a) || (w_self == r_raised_b));
        n_stage.pick    = i_in_data.random_pick;
    end

    tavs_merge u_merge (
        .i_stage (r_stage),
        .o_item  (w_merged)
    );

    // Handshake: the output register frees when empty or taken; the stage register
    // frees when empty or when it moves forward.
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_s1_adv    = r_s1_valid && w_out_ready;
    assign o_in_stall  = r_s1_valid && !w_out_ready;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_in_accept)   n_s1_valid = 1'b1;
        else if (w_s1_adv) n_s1_valid = 1'b0;

        n_out_valid = r_out_valid;
        if (w_s1_adv)         n_out_valid = 1'b1;
        else if (w_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) r_stage <= n_stage;
        if (w_s1_adv)    r_out   <= w_merged;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raised_a <= '0;
            r_raised_b <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RAISED_A: r_raised_a <= i_cfg_data[ID_BITS-1:0];
                CFG_RAISED_B: r_raised_b <= i_cfg_data[ID_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `TAVS_ASSERT_NOW(a_none_is_zero, o_out_valid && !o_out_data.handled, o_out_data.cell_column == 3'd0 && o_out_data.cell_row == 3'd0)
    `TAVS_ASSERT_NOW(a_row_range, o_out_valid, o_out_data.cell_row <= 3'd5)
    `TAVS_ASSERT_NEXT(a_stage_held, r_s1_valid && o_in_stall, r_s1_valid)
    `TAVS_ASSERT_NOW(a_no_overrun, w_in_accept, !(r_s1_valid && r_out_valid && i_out_stall))

endmodule

`default_nettype wire
